@@ rtl/core/voice_channel_allocator_defines.svh @@
// Assertion macros for the voice channel allocator.
// Taken in by the top level with `include; depends on nothing else.
`ifndef VOICE_CHANNEL_ALLOCATOR_DEFINES_SVH
`define VOICE_CHANNEL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define VCA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("voice channel allocator: assertion failed");
`define VCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("voice channel allocator: assertion failed");
`else
`define VCA_ASSERT_SAME(label, clk, rst, ante, cons)
`define VCA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/vca_pkg.sv @@
// Types and constants of the voice channel allocator.
// Depends on nothing; used by voice_channel_allocator.
`timescale 1ns / 1ps
`default_nettype none

package vca_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [13:0] VELOCITY_FULL = 14'd127;
   localparam logic [3:0]  CHANNEL_LAST  = 4'd15;

   typedef enum logic [1:0] {
      ACT_NOTE_ON  = 2'd0,
      ACT_NOTE_OFF = 2'd1,
      ACT_PITCH    = 2'd2,
      ACT_PROGRAM  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CMD_NOTE_ON  = 2'd0,
      CMD_NOTE_OFF = 2'd1,
      CMD_BEND     = 2'd2,
      CMD_PROGRAM  = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_EMIT_OFF,
      ST_EMIT_ON,
      ST_EMIT_BEND,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PROG
   } state_type;

   typedef struct packed {
      logic [7:0] voice_id;
      logic [3:0] channel;
      logic [6:0] note;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/core/voice_channel_allocator.sv @@
// Voice channel allocator: voice events in, synth commands out.
// Depends on vca_pkg and voice_channel_allocator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

// An event is taken when start is high and busy is low; busy then stays high until the
// event is finished. Results leave one per cycle on rsp_strobe and cannot be held off;
// rsp_last marks the final one of an event. The voice table sits in a single-port-write,
// registered-read memory that one sequencer walks an entry at a time: a lookup reads each
// active entry in turn before the results go out, and a note off then moves each entry
// above the freed place down one with a read and a write. A program change skips the
// lookup and sends one command to every channel; an event that is ignored ends after
// its lookup.
`include "voice_channel_allocator_defines.svh"

module voice_channel_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_voice_id,
   input  wire logic [6:0]  req_note,
   input  wire logic [13:0] req_bend,
   input  wire logic [6:0]  req_program_req,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_command,
   output logic [3:0]       rsp_channel,
   output logic [6:0]       rsp_note_out,
   output logic [13:0]      rsp_value,
   output logic             rsp_last
);

   vca_pkg::state_type  state_ff, state_in;
   vca_pkg::action_type act_ff, act_in;
   logic [7:0]  vid_ff, vid_in;
   logic [6:0]  note_ff, note_in;
   logic [13:0] bend_ff, bend_in;
   logic [6:0]  prog_ff, prog_in;

   logic [vca_pkg::CNT_W-1:0] count_ff, count_in;
   logic [vca_pkg::CNT_W-1:0] scan_ff, scan_in;
   logic                      cmp_ff, cmp_in;
   logic [vca_pkg::IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic                      hit_ff, hit_in;
   logic [vca_pkg::IDX_W-1:0] hit_idx_ff, hit_idx_in;
   vca_pkg::entry_type        hit_entry_ff, hit_entry_in;
   logic [vca_pkg::IDX_W-1:0] pos_ff, pos_in;

   logic [3:0] next_ch_ff, next_ch_in;
   logic [3:0] cur_ch_ff, cur_ch_in;
   logic [6:0] old_note_ff, old_note_in;
   logic [3:0] prog_ch_ff, prog_ch_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]  rsp_command_ff, rsp_command_in;
   logic [3:0]  rsp_channel_ff, rsp_channel_in;
   logic [6:0]  rsp_note_out_ff, rsp_note_out_in;
   logic [13:0] rsp_value_ff, rsp_value_in;
   logic        rsp_last_ff, rsp_last_in;

   // Voice table memory: one write and one registered read per cycle.
   vca_pkg::entry_type        table_mem [vca_pkg::TABLE_DEPTH];
   vca_pkg::entry_type        rd_data_ff;
   logic [vca_pkg::IDX_W-1:0] rd_addr;
   logic                      wr_en;
   logic [vca_pkg::IDX_W-1:0] wr_addr;
   vca_pkg::entry_type        wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vca_pkg::ST_IDLE;
         count_ff      <= '0;
         next_ch_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         next_ch_ff    <= next_ch_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      vid_ff          <= vid_in;
      note_ff         <= note_in;
      bend_ff         <= bend_in;
      prog_ff         <= prog_in;
      scan_ff         <= scan_in;
      cmp_ff          <= cmp_in;
      cmp_idx_ff      <= cmp_idx_in;
      hit_ff          <= hit_in;
      hit_idx_ff      <= hit_idx_in;
      hit_entry_ff    <= hit_entry_in;
      pos_ff          <= pos_in;
      cur_ch_ff       <= cur_ch_in;
      old_note_ff     <= old_note_in;
      prog_ch_ff      <= prog_ch_in;
      rsp_command_ff  <= rsp_command_in;
      rsp_channel_ff  <= rsp_channel_in;
      rsp_note_out_ff <= rsp_note_out_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_comb begin
      state_in        = state_ff;
      act_in          = act_ff;
      vid_in          = vid_ff;
      note_in         = note_ff;
      bend_in         = bend_ff;
      prog_in         = prog_ff;
      count_in        = count_ff;
      scan_in         = scan_ff;
      cmp_in          = cmp_ff;
      cmp_idx_in      = cmp_idx_ff;
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      hit_entry_in    = hit_entry_ff;
      pos_in          = pos_ff;
      next_ch_in      = next_ch_ff;
      cur_ch_in       = cur_ch_ff;
      old_note_in     = old_note_ff;
      prog_ch_in      = prog_ch_ff;
      rsp_strobe_in   = 1'b0;
      rsp_command_in  = rsp_command_ff;
      rsp_channel_in  = rsp_channel_ff;
      rsp_note_out_in = rsp_note_out_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_last_in     = rsp_last_ff;
      rd_addr         = '0;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = '{voice_id: vid_ff, channel: next_ch_ff, note: note_ff};

      unique case (state_ff)
         vca_pkg::ST_IDLE: begin
            if (start) begin
               act_in     = vca_pkg::action_type'(req_action);
               vid_in     = req_voice_id;
               note_in    = req_note;
               // Adding the offset to a two's complement value flips the sign bit; the
               // result always lies within 0..16383.
               bend_in    = {~req_bend[13], req_bend[12:0]};
               prog_in    = req_program_req;
               scan_in    = '0;
               cmp_in     = 1'b0;
               hit_in     = 1'b0;
               prog_ch_in = '0;
               if (vca_pkg::action_type'(req_action) == vca_pkg::ACT_PROGRAM) begin
                  state_in = vca_pkg::ST_PROG;
               end else begin
                  state_in = vca_pkg::ST_SEARCH;
               end
            end
         end

         vca_pkg::ST_SEARCH: begin
            // The entry read last cycle is compared while the next one is read; a later
            // match overrides an earlier one.
            if (cmp_ff && (rd_data_ff.voice_id == vid_ff)) begin
               hit_in       = 1'b1;
               hit_idx_in   = cmp_idx_ff;
               hit_entry_in = rd_data_ff;
            end
            if (scan_ff < count_ff) begin
               rd_addr    = scan_ff[vca_pkg::IDX_W-1:0];
               cmp_in     = 1'b1;
               cmp_idx_in = scan_ff[vca_pkg::IDX_W-1:0];
               scan_in    = scan_ff + vca_pkg::CNT_W'(1);
            end else begin
               cmp_in   = 1'b0;
               state_in = vca_pkg::ST_DECIDE;
            end
         end

         vca_pkg::ST_DECIDE: begin
            cur_ch_in   = hit_entry_ff.channel;
            old_note_in = hit_entry_ff.note;
            unique case (act_ff)
               vca_pkg::ACT_NOTE_ON: begin
                  cur_ch_in = next_ch_ff;
                  if (hit_ff) begin
                     wr_en      = 1'b1;
                     wr_addr    = hit_idx_ff;
                     next_ch_in = next_ch_ff + 4'd1;
                     state_in   = vca_pkg::ST_EMIT_ON;
                  end else if (count_ff == vca_pkg::CNT_W'(vca_pkg::TABLE_DEPTH)) begin
                     state_in = vca_pkg::ST_IDLE;
                  end else begin
                     wr_en      = 1'b1;
                     wr_addr    = count_ff[vca_pkg::IDX_W-1:0];
                     count_in   = count_ff + vca_pkg::CNT_W'(1);
                     next_ch_in = next_ch_ff + 4'd1;
                     state_in   = vca_pkg::ST_EMIT_ON;
                  end
               end
               vca_pkg::ACT_NOTE_OFF: begin
                  if (hit_ff) begin
                     state_in = vca_pkg::ST_EMIT_OFF;
                  end else begin
                     state_in = vca_pkg::ST_IDLE;
                  end
               end
               vca_pkg::ACT_PITCH: begin
                  if (!hit_ff) begin
                     state_in = vca_pkg::ST_IDLE;
                  end else if (hit_entry_ff.note != note_ff) begin
                     wr_en    = 1'b1;
                     wr_addr  = hit_idx_ff;
                     wr_data  = '{voice_id: hit_entry_ff.voice_id,
                                  channel:  hit_entry_ff.channel,
                                  note:     note_ff};
                     state_in = vca_pkg::ST_EMIT_OFF;
                  end else begin
                     state_in = vca_pkg::ST_EMIT_BEND;
                  end
               end
               vca_pkg::ACT_PROGRAM: begin
                  state_in = vca_pkg::ST_IDLE;
               end
            endcase
         end

         vca_pkg::ST_EMIT_OFF: begin
            rsp_strobe_in   = 1'b1;
            rsp_command_in  = vca_pkg::CMD_NOTE_OFF;
            rsp_channel_in  = cur_ch_ff;
            rsp_note_out_in = old_note_ff;
            rsp_value_in    = '0;
            rsp_last_in     = (act_ff == vca_pkg::ACT_NOTE_OFF);
            if (act_ff == vca_pkg::ACT_NOTE_OFF) begin
               pos_in = hit_idx_ff;
               if ((vca_pkg::CNT_W'(hit_idx_ff) + vca_pkg::CNT_W'(1)) < count_ff) begin
                  state_in = vca_pkg::ST_SHIFT_RD;
               end else begin
                  count_in = count_ff - vca_pkg::CNT_W'(1);
                  state_in = vca_pkg::ST_IDLE;
               end
            end else begin
               state_in = vca_pkg::ST_EMIT_ON;
            end
         end

         vca_pkg::ST_EMIT_ON: begin
            rsp_strobe_in   = 1'b1;
            rsp_command_in  = vca_pkg::CMD_NOTE_ON;
            rsp_channel_in  = cur_ch_ff;
            rsp_note_out_in = note_ff;
            rsp_value_in    = vca_pkg::VELOCITY_FULL;
            rsp_last_in     = 1'b0;
            state_in        = vca_pkg::ST_EMIT_BEND;
         end

         vca_pkg::ST_EMIT_BEND: begin
            rsp_strobe_in   = 1'b1;
            rsp_command_in  = vca_pkg::CMD_BEND;
            rsp_channel_in  = cur_ch_ff;
            rsp_note_out_in = '0;
            rsp_value_in    = bend_ff;
            rsp_last_in     = 1'b1;
            state_in        = vca_pkg::ST_IDLE;
         end

         vca_pkg::ST_SHIFT_RD: begin
            rd_addr  = pos_ff + vca_pkg::IDX_W'(1);
            state_in = vca_pkg::ST_SHIFT_WR;
         end

         vca_pkg::ST_SHIFT_WR: begin
            // The entry above the freed place moves down one; the last move also
            // shortens the table.
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = rd_data_ff;
            pos_in  = pos_ff + vca_pkg::IDX_W'(1);
            if ((vca_pkg::CNT_W'(pos_ff) + vca_pkg::CNT_W'(2)) < count_ff) begin
               state_in = vca_pkg::ST_SHIFT_RD;
            end else begin
               count_in = count_ff - vca_pkg::CNT_W'(1);
               state_in = vca_pkg::ST_IDLE;
            end
         end

         vca_pkg::ST_PROG: begin
            rsp_strobe_in   = 1'b1;
            rsp_command_in  = vca_pkg::CMD_PROGRAM;
            rsp_channel_in  = prog_ch_ff;
            rsp_note_out_in = '0;
            rsp_value_in    = {7'd0, prog_ff};
            rsp_last_in     = (prog_ch_ff == vca_pkg::CHANNEL_LAST);
            prog_ch_in      = prog_ch_ff + 4'd1;
            if (prog_ch_ff == vca_pkg::CHANNEL_LAST) begin
               state_in = vca_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = vca_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy         = (state_ff != vca_pkg::ST_IDLE);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_command  = rsp_command_ff;
   assign rsp_channel  = rsp_channel_ff;
   assign rsp_note_out = rsp_note_out_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_last     = rsp_last_ff;

   `VCA_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= vca_pkg::CNT_W'(vca_pkg::TABLE_DEPTH))
   `VCA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `VCA_ASSERT_SAME(a_prog_last, clock, reset, rsp_strobe && (rsp_command == vca_pkg::CMD_PROGRAM), rsp_last == (rsp_channel == vca_pkg::CHANNEL_LAST))

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for voice_channel_allocator: directed and random voice events,
// with every synth command compared against a behavioural voice table kept in here.
// Depends on vca_pkg and the voice_channel_allocator RTL.

module testbench;

   typedef struct packed {
      vca_pkg::command_type command;
      logic [3:0]           channel;
      logic [6:0]           note;
      logic [13:0]          value;
      logic                 last;
   } synth_command_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_action;
   logic [7:0]  req_voice_id;
   logic [6:0]  req_note;
   logic [13:0] req_bend;
   logic [6:0]  req_program_req;
   logic        rsp_strobe;
   logic [1:0]  rsp_command;
   logic [3:0]  rsp_channel;
   logic [6:0]  rsp_note_out;
   logic [13:0] rsp_value;
   logic        rsp_last;

   // Behavioural copy of the voice table.
   logic [7:0] voice_table_id [vca_pkg::TABLE_DEPTH];
   logic [3:0] voice_table_channel [vca_pkg::TABLE_DEPTH];
   logic [6:0] voice_table_note [vca_pkg::TABLE_DEPTH];
   int         active_voices;
   logic [3:0] channel_counter;

   synth_command_type expected_commands[$];
   int                mismatch_count;
   int                sender_idle_pct;
   logic [7:0]        voice_pool [24];

   voice_channel_allocator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_voice_id    (req_voice_id),
      .req_note        (req_note),
      .req_bend        (req_bend),
      .req_program_req (req_program_req),
      .rsp_strobe      (rsp_strobe),
      .rsp_command     (rsp_command),
      .rsp_channel     (rsp_channel),
      .rsp_note_out    (rsp_note_out),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   // The last matching entry wins, as in the block.
   function automatic int find_voice(logic [7:0] vid);
      int hit;
      hit = -1;
      for (int i = 0; i < active_voices; i++)
         if (voice_table_id[i] == vid) hit = i;
      return hit;
   endfunction

   function automatic void push_command(vca_pkg::command_type cmd, logic [3:0] ch,
                                        logic [6:0] nt, logic [13:0] val);
      synth_command_type c;
      c.command = cmd;
      c.channel = ch;
      c.note    = nt;
      c.value   = val;
      c.last    = 1'b0;
      expected_commands.push_back(c);
   endfunction

   // Updates the voice table for one accepted event and queues the commands it causes.
   function automatic void apply_voice_event(vca_pkg::action_type act, logic [7:0] vid,
                                             logic [6:0] nt, logic [13:0] bd,
                                             logic [6:0] prog);
      int                slot;
      int                first;
      int                bend_level;
      logic [13:0]       bend_out;
      synth_command_type tail;
      first      = expected_commands.size();
      bend_level = $signed(bd);
      bend_level = bend_level + 8192;
      if (bend_level < 0) bend_level = 0;
      if (bend_level > 16383) bend_level = 16383;
      bend_out = 14'(bend_level);
      slot     = find_voice(vid);
      case (act)
         vca_pkg::ACT_NOTE_ON: begin
            if (slot < 0 && active_voices < vca_pkg::TABLE_DEPTH) begin
               slot = active_voices;
               voice_table_id[slot] = vid;
               active_voices++;
            end
            if (slot >= 0) begin
               voice_table_note[slot]    = nt;
               voice_table_channel[slot] = channel_counter;
               channel_counter = (channel_counter == vca_pkg::CHANNEL_LAST) ?
                                 4'd0 : channel_counter + 4'd1;
               push_command(vca_pkg::CMD_NOTE_ON, voice_table_channel[slot], nt,
                            vca_pkg::VELOCITY_FULL);
               push_command(vca_pkg::CMD_BEND, voice_table_channel[slot], 7'd0, bend_out);
            end
         end
         vca_pkg::ACT_NOTE_OFF: begin
            if (slot >= 0) begin
               push_command(vca_pkg::CMD_NOTE_OFF, voice_table_channel[slot],
                            voice_table_note[slot], 14'd0);
               for (int i = slot; i + 1 < active_voices; i++) begin
                  voice_table_id[i]      = voice_table_id[i + 1];
                  voice_table_channel[i] = voice_table_channel[i + 1];
                  voice_table_note[i]    = voice_table_note[i + 1];
               end
               active_voices--;
            end
         end
         vca_pkg::ACT_PITCH: begin
            if (slot >= 0) begin
               if (voice_table_note[slot] != nt) begin
                  push_command(vca_pkg::CMD_NOTE_OFF, voice_table_channel[slot],
                               voice_table_note[slot], 14'd0);
                  voice_table_note[slot] = nt;
                  push_command(vca_pkg::CMD_NOTE_ON, voice_table_channel[slot], nt,
                               vca_pkg::VELOCITY_FULL);
               end
               push_command(vca_pkg::CMD_BEND, voice_table_channel[slot], 7'd0, bend_out);
            end
         end
         default: begin
            for (int ch = 0; ch < 16; ch++)
               push_command(vca_pkg::CMD_PROGRAM, 4'(ch), 7'd0, {7'd0, prog});
         end
      endcase
      if (expected_commands.size() > first) begin
         tail = expected_commands[expected_commands.size() - 1];
         tail.last = 1'b1;
         expected_commands[expected_commands.size() - 1] = tail;
      end
   endfunction

   // Presents one event, holds it until the block takes it, then predicts its commands.
   // Start is left high so that the next event can follow without a gap.
   task automatic send_event(vca_pkg::action_type act, logic [7:0] vid, logic [6:0] nt,
                             logic [13:0] bd, logic [6:0] prog);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_action      <= act;
      req_voice_id    <= vid;
      req_note        <= nt;
      req_bend        <= bd;
      req_program_req <= prog;
      do @(posedge clock); while (busy);
      apply_voice_event(act, vid, nt, bd, prog);
   endtask

   always @(posedge clock) begin : check_commands
      synth_command_type want;
      synth_command_type got;
      if (!reset && rsp_strobe) begin
         got.command = vca_pkg::command_type'(rsp_command);
         got.channel = rsp_channel;
         got.note    = rsp_note_out;
         got.value   = rsp_value;
         got.last    = rsp_last;
         if (expected_commands.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected command: cmd %0d ch %0d note %0d value %0d last %0d",
                        got.command, got.channel, got.note, got.value, got.last);
         end else begin
            want = expected_commands.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch cmd/ch/note/value/last: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                           want.command, want.channel, want.note, want.value, want.last,
                           got.command, got.channel, got.note, got.value, got.last);
            end
         end
      end
   end

   task automatic test_program_change;
      send_event(vca_pkg::ACT_PROGRAM, 8'h00, 7'h00, 14'h0000, 7'd0);
      send_event(vca_pkg::ACT_PROGRAM, 8'hFF, 7'h7F, 14'h3FFF, 7'd127);
   endtask

   // Bend extremes: 14'h2000 is -8192 and 14'h1FFF is 8191.
   task automatic test_note_lifecycle;
      send_event(vca_pkg::ACT_NOTE_ON, 8'h00, 7'd0, 14'h2000, 7'h7F);
      send_event(vca_pkg::ACT_NOTE_ON, 8'hFF, 7'd127, 14'h1FFF, 7'h00);
      send_event(vca_pkg::ACT_PITCH, 8'hFF, 7'd127, 14'h0000, 7'h00);
      send_event(vca_pkg::ACT_PITCH, 8'hFF, 7'd0, 14'h3FFF, 7'h00);
      send_event(vca_pkg::ACT_NOTE_ON, 8'h00, 7'd64, 14'h0064, 7'h00);
      send_event(vca_pkg::ACT_NOTE_OFF, 8'h00, 7'd5, 14'h0000, 7'h00);
      send_event(vca_pkg::ACT_NOTE_OFF, 8'hFF, 7'd0, 14'h0000, 7'h00);
   endtask

   // A pitch update and a note off for voices that are not in the table must leave no trace; a note on then adds one.
   task automatic test_unknown_voices;
      send_event(vca_pkg::ACT_PITCH, 8'd77, 7'd60, 14'h0100, 7'h00);
      send_event(vca_pkg::ACT_NOTE_OFF, 8'd78, 7'd60, 14'h0000, 7'h00);
      send_event(vca_pkg::ACT_NOTE_ON, 8'd77, 7'd60, 14'h0100, 7'h00);
   endtask

   // Fill the table, try one voice too many, then free a middle entry and retry.
   task automatic test_table_full;
      int k;
      k = 0;
      while (active_voices < vca_pkg::TABLE_DEPTH) begin
         send_event(vca_pkg::ACT_NOTE_ON, 8'h80 + 8'(k), 7'(k * 7), 14'(k * 1000), 7'h00);
         k++;
      end
      send_event(vca_pkg::ACT_NOTE_ON, 8'hC0, 7'd33, 14'h0000, 7'h00);
      send_event(vca_pkg::ACT_NOTE_OFF, 8'h83, 7'd0, 14'h0000, 7'h00);
      send_event(vca_pkg::ACT_NOTE_ON, 8'hC0, 7'd33, 14'h0000, 7'h00);
   endtask

   // Mostly events for voices that are playing, so that lookups hit and the table churns.
   task automatic test_random_traffic(int idle_pct, int count);
      int                  roll;
      int                  slot;
      vca_pkg::action_type act;
      logic [7:0]          vid;
      logic [6:0]          nt;
      sender_idle_pct = idle_pct;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         if (roll < 35) act = vca_pkg::ACT_NOTE_ON;
         else if (roll < 60) act = vca_pkg::ACT_NOTE_OFF;
         else if (roll < 92) act = vca_pkg::ACT_PITCH;
         else act = vca_pkg::ACT_PROGRAM;
         if (act != vca_pkg::ACT_NOTE_ON && active_voices > 0 && $urandom_range(99) < 85)
            vid = voice_table_id[$urandom_range(active_voices - 1)];
         else if ($urandom_range(99) < 15)
            vid = 8'($urandom);
         else
            vid = voice_pool[$urandom_range(23)];
         nt   = 7'($urandom);
         slot = find_voice(vid);
         if (act == vca_pkg::ACT_PITCH && slot >= 0 && $urandom_range(99) < 30)
            nt = voice_table_note[slot];
         send_event(act, vid, nt, 14'($urandom), 7'($urandom));
      end
   endtask

   initial begin
      int waited;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_action      <= vca_pkg::ACT_NOTE_ON;
      req_voice_id    <= 8'd0;
      req_note        <= 7'd0;
      req_bend        <= 14'd0;
      req_program_req <= 7'd0;
      mismatch_count  = 0;
      sender_idle_pct = 0;
      active_voices   = 0;
      channel_counter = 4'd0;
      for (int i = 0; i < 24; i++) voice_pool[i] = 8'($urandom);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_program_change();
      test_note_lifecycle();
      test_unknown_voices();
      test_table_full();
      test_random_traffic(0, 115);
      test_random_traffic(65, 115);
      test_random_traffic(0, 115);
      test_random_traffic(31, 115);
      @(posedge clock);
      start <= 1'b0;

      waited = 0;
      while (expected_commands.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      // Let any stray commands surface before judging.
      repeat (60) @(posedge clock);
      mismatch_count += expected_commands.size();
      if (mismatch_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/vca_pkg.sv
rtl/core/voice_channel_allocator.sv
sim/testbench.sv
